FILE: rtl/core/client_sequence_dedup_accumulator_defines.svh
// assertion macros shared by the client sequence dedup accumulator
`ifndef CLIENT_SEQUENCE_DEDUP_ACCUMULATOR_DEFINES_SVH
`define CLIENT_SEQUENCE_DEDUP_ACCUMULATOR_DEFINES_SVH

// same-cycle implication, quiet during reset
`define CSDA_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("csda: same-cycle check failed");

// next-cycle implication, quiet during reset
`define CSDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("csda: next-cycle check failed");

`endif

FILE: rtl/core/csda_pkg.sv
// types and codes shared by the client sequence dedup accumulator
`default_nettype none

package csda_pkg;

  // opcodes of an input item
  localparam logic OP_DISCOVERY = 1'b0;
  localparam logic OP_REQUEST   = 1'b1;

  // kinds of acknowledgement
  localparam logic ACK_DISCOVERY = 1'b0;
  localparam logic ACK_REQUEST   = 1'b1;

  // input item
  typedef struct packed {
    logic        opcode;
    logic [31:0] client_address;
    logic [31:0] sequence_number;
    logic [31:0] request_value;
  } csda_in_t;

  // result item
  typedef struct packed {
    logic        ack_kind;
    logic [31:0] echoed_sequence;
    logic [31:0] request_count;
    logic [63:0] running_total;
    logic        was_duplicate;
    logic        table_full;
  } csda_out_t;

  // item traveling down the row of table cells
  typedef struct packed {
    logic        active;
    logic        opcode;
    logic [31:0] addr;
    logic [31:0] seq;
    logic [31:0] value;
    logic        hit;
    logic        dup;
  } csda_tok_t;

endpackage

`default_nettype wire

FILE: rtl/core/csda_cell.sv
// one table entry: matches, registers or updates as the item passes by
`default_nettype none

module csda_cell import csda_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  csda_tok_t tok_i,
  output csda_tok_t tok_o
);

  logic        valid_q, valid_d;
  logic [31:0] addr_q, addr_d;
  logic [31:0] seq_q, seq_d;
  csda_tok_t   tok_q, tok_d;
  logic        match;

  assign match = valid_q && (addr_q == tok_i.addr);

  // lookup, registration and sequence check for the passing item
  always_comb begin
    valid_d = valid_q;
    addr_d  = addr_q;
    seq_d   = seq_q;
    tok_d   = tok_i;
    if (tok_i.active && !tok_i.hit) begin
      if (match) begin
        tok_d.hit = 1'b1;
        if (tok_i.opcode == OP_REQUEST) begin
          tok_d.dup = (tok_i.seq <= seq_q);
          if (tok_i.seq > seq_q) begin
            seq_d = tok_i.seq;
          end
        end
      end else if (!valid_q && (tok_i.opcode == OP_DISCOVERY)) begin
        // first free entry: entries fill in order, so no match lies beyond
        valid_d   = 1'b1;
        addr_d    = tok_i.addr;
        seq_d     = '0;
        tok_d.hit = 1'b1;
      end
    end
  end

  // entry valid bit and handoff register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  // entry contents, meaningful only while valid
  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    seq_q  <= seq_d;
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

FILE: rtl/core/csda_acc.sv
// request count, running sum and result formation at the end of the row
`default_nettype none

module csda_acc import csda_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  csda_tok_t tok_i,
  output logic      fire_o,
  output csda_out_t res_o
);

  logic [31:0] count_q, count_d;
  logic [63:0] sum_q, sum_d;
  logic        take;

  // a fresh request from a known client bumps the totals
  assign take    = tok_i.active && (tok_i.opcode == OP_REQUEST) && tok_i.hit && !tok_i.dup;
  assign count_d = take ? count_q + 32'd1 : count_q;
  assign sum_d   = take ? sum_q + {32'd0, tok_i.value} : sum_q;

  // discovery always answers; a request answers only for a known client
  assign fire_o = tok_i.active && ((tok_i.opcode == OP_DISCOVERY) || tok_i.hit);

  always_comb begin
    res_o = '0;
    if (tok_i.opcode == OP_DISCOVERY) begin
      res_o.ack_kind   = ACK_DISCOVERY;
      res_o.table_full = !tok_i.hit;
    end else begin
      res_o.ack_kind        = ACK_REQUEST;
      res_o.echoed_sequence = tok_i.seq;
      res_o.request_count   = count_d;
      res_o.running_total   = sum_d;
      res_o.was_duplicate   = tok_i.dup;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
    end else begin
      count_q <= count_d;
      sum_q   <= sum_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/client_sequence_dedup_accumulator.sv
// Client sequence dedup accumulator: registers client addresses and filters
// duplicate requests while summing the values of fresh ones.
// Input channel (in_valid_i / in_stall_o / in_data_i): discovery or request
// items. Output channel (out_valid_o / out_stall_i / out_data_o): one
// acknowledgement per discovery and per request from a registered client; a
// request from an unknown address gives no result.
// The client table is a row of MAX_CLIENTS cells; an item walks down it one
// cell per cycle, through the cell registers and then the output register to
// out_valid_o. One item is in the row at a time, so a new item is taken only
// after the last one has left the row.
// A result that meets a stalled output waits in a one-entry skid register;
// while it waits, in_stall_o stays high.
// Reset clears every table entry, the request count and the running sum; the
// block is ready to take an item as soon as reset is released.
`default_nettype none
`include "client_sequence_dedup_accumulator_defines.svh"

module client_sequence_dedup_accumulator import csda_pkg::*; #(
  parameter int MAX_CLIENTS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  csda_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output csda_out_t out_data_o
);

  csda_tok_t tok_w [MAX_CLIENTS+1];
  csda_tok_t tail_tok;
  csda_out_t res;
  logic      res_fire;
  logic      accept;
  logic      busy_q;
  logic      out_valid_q;
  csda_out_t out_data_q;
  logic      skid_valid_q;
  csda_out_t skid_q;
  logic      out_free;
  logic      load_out_skid;
  logic      load_out_res;
  logic      load_skid;

  assign in_stall_o = busy_q | skid_valid_q;
  assign accept     = in_valid_i & ~in_stall_o;

  // item entering the row
  always_comb begin
    tok_w[0]        = '0;
    tok_w[0].active = accept;
    tok_w[0].opcode = in_data_i.opcode;
    tok_w[0].addr   = in_data_i.client_address;
    tok_w[0].seq    = in_data_i.sequence_number;
    tok_w[0].value  = in_data_i.request_value;
  end

  // row of table cells
  for (genvar g = 0; g < MAX_CLIENTS; g++) begin : g_cell
    csda_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (tok_w[g]),
      .tok_o  (tok_w[g+1])
    );
  end

  assign tail_tok = tok_w[MAX_CLIENTS];

  csda_acc u_acc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tok_i  (tail_tok),
    .fire_o (res_fire),
    .res_o  (res)
  );

  // output register with skid behind it
  assign out_free      = ~out_valid_q | ~out_stall_i;
  assign load_out_skid = out_free & skid_valid_q;
  assign load_out_res  = out_free & ~skid_valid_q & res_fire;
  assign load_skid     = ~out_free & res_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (tail_tok.active) begin
        busy_q <= 1'b0;
      end
      if (out_free) begin
        out_valid_q <= skid_valid_q | res_fire;
      end
      if (load_out_skid) begin
        skid_valid_q <= 1'b0;
      end else if (load_skid) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load_out_skid) begin
      out_data_q <= skid_q;
    end else if (load_out_res) begin
      out_data_q <= res;
    end
    if (load_skid) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // checks on the skid and the single item in flight
  `CSDA_ASSERT_IMPLIES(a_skid_needs_full_out, clk_i, rst_ni, skid_valid_q, out_valid_q)
  `CSDA_ASSERT_IMPLIES(a_tail_only_when_busy, clk_i, rst_ni, tail_tok.active, busy_q)
  `CSDA_ASSERT_NEXT(a_result_is_kept, clk_i, rst_ni, res_fire, out_valid_q)

endmodule

`default_nettype wire
